// ----- rtl/dtp_pkg.sv -----
// Shared constants, types and helper functions for the diagnostic test pattern pixel block.
package dtp_pkg;

  localparam int MAX_DIMENSION = 8192;
  localparam int COUNTER_CELLS = 16;

  localparam int DIM_W     = 14;
  localparam int COORD_W   = 13;
  localparam int NUMBER_W  = 32;
  localparam int CHAN_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam int BAND_MIN_ROWS = 8;
  localparam int BAND_DIVISOR  = 10;

  // Reciprocal constants for exact division of a DIM_W-bit value by a constant d:
  // q = (v * (floor(2^S / d) + 1)) >> S with S = DIM_W + clog2(d).
  localparam int RECIP_W     = 16;
  localparam int CELL_SHIFT  = DIM_W + $clog2(COUNTER_CELLS);
  localparam int CELL_RECIP  = (1 << CELL_SHIFT) / COUNTER_CELLS + 1;
  localparam int TENTH_SHIFT = DIM_W + $clog2(BAND_DIVISOR);
  localparam int TENTH_RECIP = (1 << TENTH_SHIFT) / BAND_DIVISOR + 1;

  localparam logic [CHAN_W-1:0] GREY_LIT   = 8'd255;
  localparam logic [CHAN_W-1:0] GREY_DARK  = 8'd16;
  localparam logic [CHAN_W-1:0] ALPHA_FULL = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_FRAME_NUMBER = 2'd2
  } dtp_reg_e;

  typedef struct packed {
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [NUMBER_W-1:0] number;
    logic [DIM_W-1:0]    cell_w;
    logic [DIM_W-1:0]    band_rows;
  } dtp_cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              in_frame;
  } dtp_pixel_t;

  // Divide by a constant through its reciprocal.
  function automatic logic [DIM_W-1:0] div_recip(
    input logic [DIM_W-1:0]   v,
    input logic [RECIP_W-1:0] recip,
    input int                 shift
  );
    logic [DIM_W+RECIP_W-1:0] prod;
    prod = (DIM_W + RECIP_W)'(v) * (DIM_W + RECIP_W)'(recip);
    return DIM_W'(prod >> shift);
  endfunction

  // Height of the counter band: min(max(h / 10, 8), h).
  function automatic logic [DIM_W-1:0] band_rows_of(input logic [DIM_W-1:0] h);
    logic [DIM_W-1:0] tenth;
    logic [DIM_W-1:0] band;
    tenth = div_recip(h, RECIP_W'(TENTH_RECIP), TENTH_SHIFT);
    band  = (tenth > DIM_W'(BAND_MIN_ROWS)) ? tenth : DIM_W'(BAND_MIN_ROWS);
    return (band < h) ? band : h;
  endfunction

endpackage

// ----- rtl/dtp_pixel_calc.sv -----
// Combinational pixel value: pattern, counter band, frame marker and frame bounds.
module dtp_pixel_calc import dtp_pkg::*; (
  input  logic [COORD_W-1:0] pixel_x_i,
  input  logic [COORD_W-1:0] pixel_y_i,
  input  dtp_cfg_t           cfg_i,
  output dtp_pixel_t         pixel_o
);

  logic                 size_ok;
  logic                 in_bounds;
  logic                 in_band;
  logic                 marker;
  logic                 lit;
  logic [COUNTER_CELLS:0]   past_bound;
  logic [COUNTER_CELLS-1:0] cell_sel;
  logic [CHAN_W-1:0]    pat_r;
  logic [CHAN_W-1:0]    pat_g;
  logic [CHAN_W-1:0]    pat_b;
  logic [CHAN_W-1:0]    grey;
  logic [CHAN_W-1:0]    marker_byte;
  logic [CHAN_W-1:0]    f8;
  logic [CHAN_W-1:0]    x8;
  logic [CHAN_W-1:0]    y8;

  assign size_ok = (cfg_i.width != '0) && (cfg_i.height != '0) &&
                   (32'(cfg_i.width) <= 32'(MAX_DIMENSION)) &&
                   (32'(cfg_i.height) <= 32'(MAX_DIMENSION));
  assign in_bounds = ({1'b0, pixel_x_i} < cfg_i.width) &&
                     ({1'b0, pixel_y_i} < cfg_i.height);

  // Base pattern, only the low byte of every term matters.
  assign f8    = cfg_i.number[CHAN_W-1:0];
  assign x8    = pixel_x_i[CHAN_W-1:0];
  assign y8    = pixel_y_i[CHAN_W-1:0];
  assign pat_r = CHAN_W'(x8 * 8'd7) + CHAN_W'(f8 * 8'd13);
  assign pat_g = CHAN_W'(y8 * 8'd11) + CHAN_W'(f8 * 8'd29);
  assign pat_b = (x8 ^ y8) + CHAN_W'(f8 * 8'd3);

  // Thermometer of x against the cell boundaries; the last cell is open-ended.
  assign past_bound[0]             = 1'b1;
  assign past_bound[COUNTER_CELLS] = 1'b0;
  for (genvar k = 1; k < COUNTER_CELLS; k++) begin : g_bound
    logic [DIM_W-1:0] bound;
    assign bound         = DIM_W'(k * 32'(cfg_i.cell_w));
    assign past_bound[k] = ({1'b0, pixel_x_i} >= bound);
  end
  for (genvar k = 0; k < COUNTER_CELLS; k++) begin : g_sel
    assign cell_sel[k] = past_bound[k] & ~past_bound[k+1];
  end

  assign lit     = |(cell_sel & cfg_i.number[COUNTER_CELLS-1:0]);
  assign grey    = lit ? GREY_LIT : GREY_DARK;
  assign in_band = (cfg_i.cell_w != '0) && ({1'b0, pixel_y_i} < cfg_i.band_rows);
  assign marker  = (cfg_i.width >= DIM_W'(4)) && (pixel_y_i == '0) &&
                   (pixel_x_i < COORD_W'(4));

  // Frame number, most significant byte first.
  always_comb begin
    case (pixel_x_i[1:0])
      2'd0:    marker_byte = cfg_i.number[31:24];
      2'd1:    marker_byte = cfg_i.number[23:16];
      2'd2:    marker_byte = cfg_i.number[15:8];
      default: marker_byte = cfg_i.number[7:0];
    endcase
  end

  always_comb begin
    pixel_o = '0;
    if (size_ok && in_bounds) begin
      pixel_o.red      = marker ? marker_byte : (in_band ? grey : pat_r);
      pixel_o.green    = in_band ? grey : pat_g;
      pixel_o.blue     = in_band ? grey : pat_b;
      pixel_o.alpha    = ALPHA_FULL;
      pixel_o.in_frame = 1'b1;
    end
  end

endmodule

// ----- rtl/diagnostic_test_pattern_pixel.sv -----
// Top level of the diagnostic test pattern pixel generator.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+--------------------------------------
//  in      | sink      | in_valid_i / in_stall_o  | pixel_x_i, pixel_y_i
//  out     | source    | out_valid_o / out_stall_i | red_o, green_o, blue_o, alpha_o,
//          |           |                        | in_frame_o
//  cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One pixel per cycle sustained while the output is not stalled; a pixel passes through
// the input register, then the result register, on its way to the output.
// The input register and the result register form a two-entry pipeline, so a new
// transaction is taken while a finished pixel waits under stall.
// Reset clears the valid flags and all configuration registers (size 0, frame invalid).
// Derived values (cell width, band height) are computed from the write data and
// registered in the same edge as the register they come from.
module diagnostic_test_pattern_pixel import dtp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Pixel request
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_W-1:0]    pixel_x_i,
  input  logic [COORD_W-1:0]    pixel_y_i,
  // Pixel result
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CHAN_W-1:0]     red_o,
  output logic [CHAN_W-1:0]     green_o,
  output logic [CHAN_W-1:0]     blue_o,
  output logic [CHAN_W-1:0]     alpha_o,
  output logic                  in_frame_o,
  // Configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dtp_cfg_t         cfg_q;
  logic [DIM_W-1:0] wdata_dim;

  logic                s1_valid_q;
  logic [COORD_W-1:0]  px_q;
  logic [COORD_W-1:0]  py_q;
  logic                out_valid_q;
  dtp_pixel_t          pixel_d;
  dtp_pixel_t          pixel_q;
  logic                adv_out;
  logic                take_in;

  // Configuration: always ready; a write is registered straight into the configuration.
  assign cfg_ready_o = 1'b1;
  assign wdata_dim   = cfg_data_i[DIM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (dtp_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH: begin
          cfg_q.width  <= wdata_dim;
          cfg_q.cell_w <= div_recip(wdata_dim, RECIP_W'(CELL_RECIP), CELL_SHIFT);
        end
        REG_FRAME_HEIGHT: begin
          cfg_q.height    <= wdata_dim;
          cfg_q.band_rows <= band_rows_of(wdata_dim);
        end
        REG_FRAME_NUMBER: begin
          cfg_q.number <= cfg_data_i[NUMBER_W-1:0];
        end
        default: begin
          // Drop writes to unmapped indexes.
        end
      endcase
    end
  end

  // Pipeline control: the result register advances when empty or drained; the
  // input register loads whenever the result register advances or it is itself empty.
  assign adv_out    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv_out;
  assign take_in    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_out) begin
        out_valid_q <= s1_valid_q;
      end
      if (adv_out || !s1_valid_q) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  // Payload registers: hold while stalled.
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      px_q <= pixel_x_i;
      py_q <= pixel_y_i;
    end
    if (adv_out && s1_valid_q) begin
      pixel_q <= pixel_d;
    end
  end

  dtp_pixel_calc u_calc (
    .pixel_x_i (px_q),
    .pixel_y_i (py_q),
    .cfg_i     (cfg_q),
    .pixel_o   (pixel_d)
  );

  assign out_valid_o = out_valid_q;
  assign red_o       = pixel_q.red;
  assign green_o     = pixel_q.green;
  assign blue_o      = pixel_q.blue;
  assign alpha_o     = pixel_q.alpha;
  assign in_frame_o  = pixel_q.in_frame;

  // A pending pixel moves into the result register whenever the output is not stalled.
  a_pipe_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_stall_i |=> out_valid_q)
    else $error("pending pixel did not reach the result register");

  // An out-of-frame result carries all-zero channels.
  a_out_of_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_frame_o |->
      (red_o == '0) && (green_o == '0) && (blue_o == '0) && (alpha_o == '0))
    else $error("out-of-frame pixel with nonzero channels");

  // An in-frame result is opaque.
  a_in_frame_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_frame_o |-> (alpha_o == ALPHA_FULL))
    else $error("in-frame pixel not opaque");

  // Derived geometry never exceeds the frame it was derived from.
  a_derived_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_q.cell_w <= cfg_q.width) && (cfg_q.band_rows <= cfg_q.height))
    else $error("derived cell width or band height out of range");

endmodule

// ----- tb/diagnostic_test_pattern_pixel_test.sv -----
// Self-checking testbench for the diagnostic test pattern pixel generator.
`timescale 1ns / 1ps

module diagnostic_test_pattern_pixel_test;
  import dtp_pkg::*;

  // One pixel request as it travels to the block.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pixel_req_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [COORD_W-1:0]    pixel_x_i;
  logic [COORD_W-1:0]    pixel_y_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [CHAN_W-1:0]     red_o;
  logic [CHAN_W-1:0]     green_o;
  logic [CHAN_W-1:0]     blue_o;
  logic [CHAN_W-1:0]     alpha_o;
  logic                  in_frame_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Shadow copy of the configuration, updated on each accepted write.
  logic [DIM_W-1:0]    frame_w;
  logic [DIM_W-1:0]    frame_h;
  logic [NUMBER_W-1:0] frame_num;

  pixel_req_t  request_q[$];       // pixels waiting to be driven
  dtp_pixel_t  pixel_expect_q[$];  // predicted pixels, oldest first
  dtp_pixel_t  pixel_want;
  bit          req_fire;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned fail_count;

  diagnostic_test_pattern_pixel u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o),
    .alpha_o    (alpha_o),
    .in_frame_o (in_frame_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Rows covered by the counter band: a tenth of the height, at least
  // BAND_MIN_ROWS, never more than the frame itself.
  function automatic int unsigned band_height(input int unsigned h);
    int unsigned band;
    band = h / BAND_DIVISOR;
    if (band < BAND_MIN_ROWS) band = BAND_MIN_ROWS;
    return (band < h) ? band : h;
  endfunction

  // Predict the pixel for one coordinate under the current configuration.
  // Layers, lowest first: arithmetic pattern, counter band, frame-number marker.
  function automatic dtp_pixel_t pattern_pixel(input logic [COORD_W-1:0] px,
                                               input logic [COORD_W-1:0] py);
    dtp_pixel_t        p;
    int unsigned       x;
    int unsigned       y;
    int unsigned       w;
    int unsigned       h;
    int unsigned       f;
    int unsigned       cell_w;
    int unsigned       cell_idx;
    logic [CHAN_W-1:0] grey;
    p = '0;
    x = px;
    y = py;
    w = frame_w;
    h = frame_h;
    // Invalid size or coordinate outside: all-zero pixel, in_frame low.
    if (w == 0 || h == 0 || w > MAX_DIMENSION || h > MAX_DIMENSION || x >= w || y >= h)
      return p;
    // Pattern runs off the low 24 bits of the frame number only.
    f = frame_num & 32'h00FF_FFFF;
    p.red      = CHAN_W'(x * 7 + f * 13);
    p.green    = CHAN_W'(y * 11 + f * 29);
    p.blue     = CHAN_W'((x ^ y) + f * 3);
    p.alpha    = ALPHA_FULL;
    p.in_frame = 1'b1;
    // Counter band exists only when each cell is at least one column wide;
    // the last cell soaks up the leftover columns.
    cell_w = w / COUNTER_CELLS;
    if (cell_w > 0 && y < band_height(h)) begin
      cell_idx = x / cell_w;
      if (cell_idx > COUNTER_CELLS - 1) cell_idx = COUNTER_CELLS - 1;
      grey = frame_num[cell_idx] ? GREY_LIT : GREY_DARK;
      p.red   = grey;
      p.green = grey;
      p.blue  = grey;
    end
    // Marker: red of row 0, columns 0..3, carries the frame number MSB first.
    if (w >= 4 && y == 0 && x < 4)
      p.red = CHAN_W'(frame_num >> ((3 - x) * 8));
    return p;
  endfunction

  // Driver: register each accepted transaction and predict its pixel.
  always @(posedge clk_i) begin
    req_fire = in_valid_i && !in_stall_o;
    if (req_fire)
      pixel_expect_q.push_back(pattern_pixel(pixel_x_i, pixel_y_i));
  end

  // Driver: advance to the next request once the current one is taken,
  // idling at random; hold the payload while stalled.
  always @(negedge clk_i) begin
    if (!in_valid_i || req_fire) begin
      if (request_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        pixel_req_t req;
        req = request_q.pop_front();
        in_valid_i <= 1'b1;
        pixel_x_i  <= req.x;
        pixel_y_i  <= req.y;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: stall at random; changes land on the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_idle_pct);
  end

  task automatic check_channel(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Monitor: compare every accepted pixel with the oldest prediction.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (pixel_expect_q.size() == 0) begin
        fail_count++;
        $display("%0t: pixel with nothing expected, expected none, actual r=%0d g=%0d b=%0d a=%0d in=%0d",
                 $time, red_o, green_o, blue_o, alpha_o, in_frame_o);
      end else begin
        pixel_want = pixel_expect_q.pop_front();
        check_channel("red",      pixel_want.red,      red_o);
        check_channel("green",    pixel_want.green,    green_o);
        check_channel("blue",     pixel_want.blue,     blue_o);
        check_channel("alpha",    pixel_want.alpha,    alpha_o);
        check_channel("in_frame", pixel_want.in_frame, in_frame_o);
      end
    end
  end

  // Block until nothing is queued, driven or outstanding. Looks shortly after a
  // falling edge, once the driver's update has settled, and returns there.
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
      #1;
    end while (request_q.size() != 0 || in_valid_i || pixel_expect_q.size() != 0);
  endtask

  // Write one register; entered in the low clock phase and left on a falling
  // edge, valid left high.
  task automatic write_reg(input dtp_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_FRAME_WIDTH:  frame_w   = data[DIM_W-1:0];
      REG_FRAME_HEIGHT: frame_h   = data[DIM_W-1:0];
      REG_FRAME_NUMBER: frame_num = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Drain the block, then load a full frame setting. Returns on a rising edge
  // so that new requests never race the driver.
  task automatic set_frame(input logic [CFG_DATA_W-1:0] w_data,
                           input logic [CFG_DATA_W-1:0] h_data,
                           input logic [CFG_DATA_W-1:0] num);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, w_data);
    write_reg(REG_FRAME_HEIGHT, h_data);
    write_reg(REG_FRAME_NUMBER, num);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic queue_pixel(input int unsigned x, input int unsigned y);
    request_q.push_back('{x: COORD_W'(x), y: COORD_W'(y)});
  endtask

  // Random requests aimed at the interesting regions of the current frame:
  // mostly in the frame, with weight on the marker, the band and the right edge,
  // plus some coordinates anywhere in the field range.
  task automatic queue_random_pixels(input int count);
    int unsigned wl;
    int unsigned hl;
    int unsigned band;
    int unsigned pick;
    int unsigned x;
    int unsigned y;
    wl   = (frame_w == 0 || frame_w > MAX_DIMENSION) ? MAX_DIMENSION : frame_w;
    hl   = (frame_h == 0 || frame_h > MAX_DIMENSION) ? MAX_DIMENSION : frame_h;
    band = band_height(hl);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      x    = $urandom_range(wl - 1);
      y    = $urandom_range(hl - 1);
      if (pick < 10) begin
        x = $urandom_range((1 << COORD_W) - 1);
        y = $urandom_range((1 << COORD_W) - 1);
      end else if (pick < 25) begin
        y = 0;
        x = $urandom_range((wl < 6) ? wl - 1 : 5);
      end else if (pick < 55) begin
        y = $urandom_range(band - 1);
      end else if (pick < 62) begin
        x = wl - 1;
      end
      queue_pixel(x, y);
    end
  endtask

  // Stimulus: reset, directed corners, then random frames under three idle profiles.
  initial begin
    logic [CFG_DATA_W-1:0] w_cfg;
    logic [CFG_DATA_W-1:0] h_cfg;
    logic [CFG_DATA_W-1:0] n_cfg;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    pixel_x_i    = '0;
    pixel_y_i    = '0;
    out_stall_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = REG_FRAME_WIDTH;
    cfg_data_i   = '0;
    frame_w      = '0;
    frame_h      = '0;
    frame_num    = '0;
    fail_count   = 0;
    in_idle_pct  = 11;
    out_idle_pct = 46;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Out of reset the frame size is zero: everything is out of frame.
    queue_pixel(0, 0);

    // 64x100: cells four columns wide, band of ten rows.
    set_frame(64, 100, 32'hA5C3_1E7F);
    queue_pixel(0, 0);       // marker bytes, most significant first
    queue_pixel(1, 0);
    queue_pixel(2, 0);
    queue_pixel(3, 0);
    queue_pixel(4, 0);       // band just past the marker
    queue_pixel(63, 5);      // last cell
    queue_pixel(60, 9);      // last band row
    queue_pixel(10, 10);     // first row below the band
    queue_pixel(5, 50);
    queue_pixel(63, 99);     // bottom-right corner
    queue_pixel(64, 0);      // one column past the edge
    queue_pixel(0, 100);     // one row past the edge
    queue_pixel(8191, 8191);

    // Too narrow for both cells and marker.
    set_frame(3, 5, 32'h1234_5678);
    queue_pixel(0, 0);
    queue_pixel(2, 4);
    queue_pixel(3, 0);

    // Largest frame, all frame bits set.
    set_frame(MAX_DIMENSION, MAX_DIMENSION, 32'hFFFF_FFFF);
    queue_pixel(8191, 8191);
    queue_pixel(0, 0);
    queue_pixel(8191, 0);
    queue_pixel(4096, 818);
    queue_pixel(4096, 819);

    // Width one past the maximum, then zero height: both invalid.
    set_frame(MAX_DIMENSION + 1, 100, 32'h0000_0001);
    queue_pixel(0, 0);
    set_frame(100, 0, 32'h8000_0000);
    queue_pixel(0, 0);

    // Random frames: four per idle profile, a spread of shapes in each.
    for (int k = 0; k < 12; k++) begin
      n_cfg = $urandom;
      case (k % 6)
        0: begin
          w_cfg = MAX_DIMENSION;
          h_cfg = MAX_DIMENSION;
        end
        1: begin
          w_cfg = $urandom_range(1, 64);
          h_cfg = $urandom_range(1, 40);
        end
        2: begin
          w_cfg = $urandom_range(1, MAX_DIMENSION);
          h_cfg = $urandom_range(1, MAX_DIMENSION);
        end
        3: begin
          w_cfg = $urandom_range(16, 47);
          h_cfg = $urandom_range(1, 12);
          n_cfg = (k < 6) ? 32'h0000_0000 : 32'hFFFF_FFFF;
        end
        4: begin
          if (k < 6) begin
            w_cfg = $urandom_range(1) ? 0 : $urandom_range(MAX_DIMENSION + 1, 16383);
            h_cfg = $urandom_range(1, 200);
          end else begin
            w_cfg = $urandom_range(1, 200);
            h_cfg = $urandom_range(1) ? 0 : $urandom_range(MAX_DIMENSION + 1, 16383);
          end
        end
        default: begin
          w_cfg = $urandom_range(1, 4);
          h_cfg = $urandom_range(1, MAX_DIMENSION);
        end
      endcase
      // Drop noise into the unused upper write bits now and then.
      if ($urandom_range(1)) w_cfg = w_cfg | ($urandom & 32'hFFFF_C000);
      if ($urandom_range(1)) h_cfg = h_cfg | ($urandom & 32'hFFFF_C000);
      set_frame(w_cfg, h_cfg, n_cfg);
      case (k / 4)
        0: begin
          in_idle_pct  = 11;
          out_idle_pct = 46;
        end
        1: begin
          in_idle_pct  = 46;
          out_idle_pct = 11;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      queue_random_pixels(146);
    end

    // Drain, then give a stray pixel a few edges to show up.
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
